// ----- rtl/lct_pkg.sv -----
// Shared types, operation codes and constants of the link connection table.
`default_nettype none
package lct_pkg;

    localparam int unsigned LCT_RESERVED_HANDLE = 3839;
    localparam int unsigned LCT_MAX_LINKS       = 16;

    localparam logic [7:0] LCT_LE_TYPE_IDLE = 8'hBA;

    typedef enum logic [3:0] {
        OP_PEND_CLASSIC     = 4'd0,
        OP_CANCEL_CLASSIC   = 4'd1,
        OP_PEND_LE          = 4'd2,
        OP_CANCEL_LE        = 4'd3,
        OP_COMPLETE_CLASSIC = 4'd4,
        OP_COMPLETE_LE      = 4'd5,
        OP_DISCONNECT       = 4'd6,
        OP_FIND_BY_ADDRESS  = 4'd7,
        OP_QUERY_HANDLE     = 4'd8,
        OP_ENCRYPT          = 4'd9,
        OP_DEVICE_CONNECTED = 4'd10,
        OP_HAS_PEND_CLASSIC = 4'd11,
        OP_HAS_PEND_LE      = 4'd12
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_CHECK,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [3:0]  operation;
        logic [47:0] peer_address;
        logic [7:0]  peer_address_type;
        logic [7:0]  local_address_type;
        logic [11:0] link_handle;
    } t_in_item;

    typedef struct packed {
        logic        ok;
        logic [11:0] result_handle;
        logic [47:0] result_address;
        logic [7:0]  result_address_type;
        logic [7:0]  result_local_type;
        logic        result_encrypted;
        logic        table_full;
    } t_out_item;

    typedef struct packed {
        logic [11:0] handle;
        logic [47:0] address;
        logic [7:0]  addr_type;
        logic [7:0]  local_type;
        logic        encrypted;
    } t_entry;

endpackage
`default_nettype wire

// ----- rtl/lct_store.sv -----
// Connection entry memory with per-entry valid bits and a lowest-free-entry encoder.
`default_nettype none
module lct_store
    import lct_pkg::*;
#(
    parameter int unsigned MAX_LINKS = LCT_MAX_LINKS,
    parameter int unsigned IW        = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [IW-1:0]        i_rd_idx,
    output t_entry                    o_rd_data,
    output logic [MAX_LINKS-1:0]      o_valid_bits,
    input  wire logic                 i_wr_en,
    input  wire logic [IW-1:0]        i_wr_idx,
    input  wire t_entry               i_wr_data,
    input  wire logic                 i_clr_en,
    input  wire logic [IW-1:0]        i_clr_idx,
    output logic                      o_free_found,
    output logic [IW-1:0]             o_free_idx
);

    t_entry               mem [MAX_LINKS];
    t_entry               r_rd_data;
    logic [MAX_LINKS-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_idx] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_idx];
    end

    // A write always makes its entry live; a disconnect only drops the valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_clr_en) begin
                r_valid[i_clr_idx] <= 1'b0;
            end
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
        end
    end

    always_comb begin
        o_free_found = 1'b0;
        o_free_idx   = '0;
        for (int i = MAX_LINKS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                o_free_found = 1'b1;
                o_free_idx   = IW'(i);
            end
        end
    end

    assign o_rd_data    = r_rd_data;
    assign o_valid_bits = r_valid;

endmodule
`default_nettype wire

// ----- rtl/link_connection_table.sv -----
// Link connection table: pending classic and low-energy requests and a table of live links.
// One transaction is taken at a time. Pending-request operations other than a low-energy
// pend, and unused codes, go from the accepting state through the execute state to the finish
// state. Address and handle searches walk the entry memory through its single read port, with
// a read and a check state per entry, stopping early on a hit except in a find by address,
// which visits every entry. A completion tests each candidate handle against every entry in
// the same way and moves to the next candidate on a clash. At most K candidates are tried,
// where K is the smaller of MAX_LINKS and RESERVED_HANDLE.
// A finished result waits in an output register while the next transaction is accepted.
`default_nettype none
module link_connection_table
    import lct_pkg::*;
#(
    parameter int unsigned RESERVED_HANDLE = LCT_RESERVED_HANDLE,
    parameter int unsigned MAX_LINKS       = LCT_MAX_LINKS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    localparam int unsigned IW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
    localparam logic [11:0] RES_H = 12'(RESERVED_HANDLE);

    t_state      r_state, n_state;
    t_in_item    r_in, n_in;
    t_out_item   r_res, n_res;
    t_out_item   r_out;
    logic        r_ovld;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_slot, n_slot;
    logic [11:0] r_cand, n_cand;
    logic [11:0] r_tries, n_tries;
    logic [11:0] r_cursor, n_cursor;
    logic        r_cl_pend, n_cl_pend;
    logic [47:0] r_cl_addr, n_cl_addr;
    logic        r_le_pend, n_le_pend;
    logic [47:0] r_le_addr, n_le_addr;
    logic [7:0]  r_le_type, n_le_type;

    t_entry               rd_data;
    logic [MAX_LINKS-1:0] valid_bits;
    logic                 free_found;
    logic [IW-1:0]        free_idx;
    logic                 wr_en;
    logic [IW-1:0]        wr_idx;
    t_entry               wr_data;
    logic                 clr_en;

    logic        accept;
    logic        out_free;
    logic        c_last, c_v, c_addr_eq, c_dev_hit, c_h_hit, c_cand_hit;
    logic        c_cl_match, c_le_match, c_tries_out;
    logic [11:0] c_cand_next;

    lct_store #(
        .MAX_LINKS (MAX_LINKS),
        .IW        (IW)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_idx     (r_idx),
        .o_rd_data    (rd_data),
        .o_valid_bits (valid_bits),
        .i_wr_en      (wr_en),
        .i_wr_idx     (wr_idx),
        .i_wr_data    (wr_data),
        .i_clr_en     (clr_en),
        .i_clr_idx    (r_idx),
        .o_free_found (free_found),
        .o_free_idx   (free_idx)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_ovld || i_out_ready;
    assign o_out_valid = r_ovld;
    assign o_out_item  = r_out;

    // Compare unit shared by every scan.
    always_comb begin
        c_last      = (r_idx == IW'(MAX_LINKS - 1));
        c_v         = valid_bits[r_idx];
        c_addr_eq   = (rd_data.address == r_in.peer_address);
        c_dev_hit   = c_v && c_addr_eq && (rd_data.addr_type == r_in.peer_address_type);
        c_h_hit     = c_v && (rd_data.handle == r_in.link_handle);
        c_cand_hit  = c_v && (rd_data.handle == r_cand);
        c_cl_match  = r_cl_pend && (r_cl_addr == r_in.peer_address);
        c_le_match  = r_le_pend && (r_le_addr == r_in.peer_address)
                      && (r_le_type == r_in.peer_address_type);
        c_tries_out = ((13'(r_tries) + 13'd1) == 13'(RESERVED_HANDLE));
        c_cand_next = (r_cand == RES_H - 12'd1) ? 12'd0 : r_cand + 12'd1;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (r_in.operation)
                    OP_PEND_LE:          n_state = r_le_pend ? ST_FIN : ST_READ;
                    OP_DEVICE_CONNECTED,
                    OP_DISCONNECT,
                    OP_QUERY_HANDLE,
                    OP_ENCRYPT,
                    OP_FIND_BY_ADDRESS:  n_state = ST_READ;
                    OP_COMPLETE_CLASSIC: n_state = (c_cl_match && free_found) ? ST_READ : ST_FIN;
                    OP_COMPLETE_LE:      n_state = (c_le_match && free_found) ? ST_READ : ST_FIN;
                    default:             n_state = ST_FIN;
                endcase
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                case (r_in.operation)
                    OP_PEND_LE,
                    OP_DEVICE_CONNECTED: n_state = (c_dev_hit || c_last) ? ST_FIN : ST_READ;
                    OP_DISCONNECT,
                    OP_QUERY_HANDLE,
                    OP_ENCRYPT:          n_state = (c_h_hit || c_last) ? ST_FIN : ST_READ;
                    OP_FIND_BY_ADDRESS:  n_state = c_last ? ST_FIN : ST_READ;
                    OP_COMPLETE_CLASSIC,
                    OP_COMPLETE_LE: begin
                        if (c_cand_hit) begin
                            n_state = c_tries_out ? ST_FIN : ST_READ;
                        end else begin
                            n_state = c_last ? ST_FIN : ST_READ;
                        end
                    end
                    default:             n_state = ST_FIN;
                endcase
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_in      = r_in;
        n_res     = r_res;
        n_idx     = r_idx;
        n_slot    = r_slot;
        n_cand    = r_cand;
        n_tries   = r_tries;
        n_cursor  = r_cursor;
        n_cl_pend = r_cl_pend;
        n_cl_addr = r_cl_addr;
        n_le_pend = r_le_pend;
        n_le_addr = r_le_addr;
        n_le_type = r_le_type;
        wr_en     = 1'b0;
        wr_idx    = r_slot;
        wr_data   = rd_data;
        clr_en    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_in    = i_in_item;
                    n_res   = '0;
                    n_res.result_handle = RES_H;
                    n_idx   = '0;
                    n_cand  = r_cursor;
                    n_tries = '0;
                end
            end
            ST_EXEC: begin
                n_slot = free_idx;
                case (r_in.operation)
                    OP_PEND_CLASSIC: begin
                        if (!r_cl_pend) begin
                            n_cl_pend = 1'b1;
                            n_cl_addr = r_in.peer_address;
                            n_res.ok  = 1'b1;
                        end
                    end
                    OP_CANCEL_CLASSIC: begin
                        if (c_cl_match) begin
                            n_cl_pend = 1'b0;
                            n_cl_addr = '0;
                            n_res.ok  = 1'b1;
                        end
                    end
                    OP_CANCEL_LE: begin
                        if (c_le_match) begin
                            n_le_pend = 1'b0;
                            n_le_addr = '0;
                            n_le_type = LCT_LE_TYPE_IDLE;
                            n_res.ok  = 1'b1;
                        end
                    end
                    OP_HAS_PEND_CLASSIC: n_res.ok = c_cl_match;
                    OP_HAS_PEND_LE:      n_res.ok = c_le_match;
                    OP_COMPLETE_CLASSIC: n_res.table_full = c_cl_match && !free_found;
                    OP_COMPLETE_LE:      n_res.table_full = c_le_match && !free_found;
                    default: ;
                endcase
            end
            ST_CHECK: begin
                n_idx = r_idx + IW'(1);
                case (r_in.operation)
                    OP_PEND_LE: begin
                        if (!c_dev_hit && c_last) begin
                            n_le_pend = 1'b1;
                            n_le_addr = r_in.peer_address;
                            n_le_type = r_in.peer_address_type;
                            n_res.ok  = 1'b1;
                        end
                    end
                    OP_DEVICE_CONNECTED: begin
                        if (c_dev_hit) begin
                            n_res.ok = 1'b1;
                        end
                    end
                    OP_DISCONNECT: begin
                        if (c_h_hit) begin
                            clr_en              = 1'b1;
                            n_res.ok            = 1'b1;
                            n_res.result_handle = r_in.link_handle;
                        end
                    end
                    OP_QUERY_HANDLE: begin
                        if (c_h_hit) begin
                            n_res.ok                  = 1'b1;
                            n_res.result_handle       = r_in.link_handle;
                            n_res.result_address      = rd_data.address;
                            n_res.result_address_type = rd_data.addr_type;
                            n_res.result_local_type   = rd_data.local_type;
                            n_res.result_encrypted    = rd_data.encrypted;
                        end
                    end
                    OP_ENCRYPT: begin
                        if (c_h_hit) begin
                            wr_en               = 1'b1;
                            wr_idx              = r_idx;
                            wr_data.encrypted   = 1'b1;
                            n_res.ok            = 1'b1;
                            n_res.result_handle = r_in.link_handle;
                        end
                    end
                    OP_FIND_BY_ADDRESS: begin
                        if (c_v && c_addr_eq
                            && (!r_res.ok || rd_data.handle < r_res.result_handle)) begin
                            n_res.ok            = 1'b1;
                            n_res.result_handle = rd_data.handle;
                        end
                    end
                    OP_COMPLETE_CLASSIC,
                    OP_COMPLETE_LE: begin
                        if (c_cand_hit) begin
                            // The candidate is taken: try the next one from the first entry.
                            n_cand           = c_cand_next;
                            n_tries          = r_tries + 12'd1;
                            n_idx            = '0;
                            n_res.table_full = c_tries_out;
                        end else if (c_last) begin
                            wr_en                = 1'b1;
                            wr_data.handle       = r_cand;
                            wr_data.address      = r_in.peer_address;
                            wr_data.encrypted    = 1'b0;
                            n_cursor             = c_cand_next;
                            n_res.ok             = 1'b1;
                            n_res.result_handle  = r_cand;
                            if (r_in.operation == OP_COMPLETE_LE) begin
                                wr_data.addr_type    = r_in.peer_address_type;
                                wr_data.local_type   = r_in.local_address_type;
                                n_le_pend            = 1'b0;
                                n_le_addr            = '0;
                                n_le_type            = LCT_LE_TYPE_IDLE;
                            end else begin
                                wr_data.addr_type    = '0;
                                wr_data.local_type   = '0;
                                n_cl_pend            = 1'b0;
                                n_cl_addr            = '0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ovld    <= 1'b0;
            r_cursor  <= '0;
            r_cl_pend <= 1'b0;
            r_cl_addr <= '0;
            r_le_pend <= 1'b0;
            r_le_addr <= '0;
            r_le_type <= LCT_LE_TYPE_IDLE;
        end else begin
            r_state   <= n_state;
            r_cursor  <= n_cursor;
            r_cl_pend <= n_cl_pend;
            r_cl_addr <= n_cl_addr;
            r_le_pend <= n_le_pend;
            r_le_addr <= n_le_addr;
            r_le_type <= n_le_type;
            if (r_state == ST_FIN && out_free) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in    <= n_in;
        r_res   <= n_res;
        r_idx   <= n_idx;
        r_slot  <= n_slot;
        r_cand  <= n_cand;
        r_tries <= n_tries;
        if (r_state == ST_FIN && out_free) begin
            r_out <= r_res;
        end
    end

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor < RES_H)
        else $error("handle cursor reached the reserved handle");

    a_ok_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.ok && o_out_item.table_full))
        else $error("result reports success and a full table together");

    a_classic_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cl_pend |-> (r_cl_addr == '0))
        else $error("classic pending address kept without a pending request");

    a_le_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_le_pend |-> (r_le_addr == '0 && r_le_type == LCT_LE_TYPE_IDLE))
        else $error("low-energy pending fields kept without a pending request");

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench of the link connection table with a scoreboard class.
`default_nettype none
module testbench;
    import lct_pkg::*;

    localparam int unsigned RSV = LCT_RESERVED_HANDLE;
    localparam int unsigned LINKS = LCT_MAX_LINKS;

    // Software mirror of the connection table and the pending requests.
    class link_table_scoreboard;
        bit          cl_pend;
        bit [47:0]   cl_addr;
        bit          le_pend;
        bit [47:0]   le_addr;
        bit [7:0]    le_type;
        bit [11:0]   cursor;
        bit          valid [LINKS];
        t_entry      ent [LINKS];
        t_out_item   pending_results [$];
        int          errors;

        function new();
            cl_pend = 0; cl_addr = 0; le_pend = 0; le_addr = 0;
            le_type = LCT_LE_TYPE_IDLE; cursor = 0; errors = 0;
            foreach (valid[i]) valid[i] = 0;
        endfunction

        function int slot_of(bit [11:0] h);
            for (int i = 0; i < LINKS; i++)
                if (valid[i] && ent[i].handle == h) return i;
            return -1;
        endfunction

        function bit present(bit [47:0] a, bit [7:0] t);
            for (int i = 0; i < LINKS; i++)
                if (valid[i] && ent[i].address == a && ent[i].addr_type == t) return 1;
            return 0;
        endfunction

        // Returns the filled slot, or -1 when no slot or handle is free.
        function int allocate(bit [47:0] a, bit [7:0] t, bit [7:0] own);
            int slot;
            int unsigned cand;
            slot = -1;
            cand = cursor;
            for (int i = 0; i < LINKS; i++)
                if (!valid[i]) begin
                    slot = i;
                    break;
                end
            if (slot < 0) return -1;
            for (int unsigned n = 0; n < RSV; n++) begin
                if (cand >= RSV) cand = 0;
                if (slot_of(cand[11:0]) < 0) begin
                    valid[slot] = 1;
                    ent[slot] = '{cand[11:0], a, t, own, 1'b0};
                    cursor = 12'((cand + 1) % RSV);
                    return slot;
                end
                cand++;
            end
            return -1;
        endfunction

        function void note_input(t_in_item it);
            t_out_item r;
            int s;
            bit le_m, cl_m;
            r = '0;
            r.result_handle = RSV[11:0];
            le_m = le_pend && le_addr == it.peer_address && le_type == it.peer_address_type;
            cl_m = cl_pend && cl_addr == it.peer_address;
            case (it.operation)
                OP_PEND_CLASSIC: if (!cl_pend) begin
                    cl_pend = 1; cl_addr = it.peer_address; r.ok = 1;
                end
                OP_CANCEL_CLASSIC: if (cl_m) begin
                    cl_pend = 0; cl_addr = 0; r.ok = 1;
                end
                OP_PEND_LE: if (!present(it.peer_address, it.peer_address_type) && !le_pend) begin
                    le_pend = 1; le_addr = it.peer_address;
                    le_type = it.peer_address_type; r.ok = 1;
                end
                OP_CANCEL_LE: if (le_m) begin
                    le_pend = 0; le_addr = 0; le_type = LCT_LE_TYPE_IDLE; r.ok = 1;
                end
                OP_COMPLETE_CLASSIC: if (cl_m) begin
                    s = allocate(it.peer_address, 8'd0, 8'd0);
                    if (s < 0) r.table_full = 1;
                    else begin
                        cl_pend = 0; cl_addr = 0; r.ok = 1;
                        r.result_handle = ent[s].handle;
                    end
                end
                OP_COMPLETE_LE: if (le_m) begin
                    s = allocate(it.peer_address, it.peer_address_type, it.local_address_type);
                    if (s < 0) r.table_full = 1;
                    else begin
                        le_pend = 0; le_addr = 0; le_type = LCT_LE_TYPE_IDLE; r.ok = 1;
                        r.result_handle = ent[s].handle;
                    end
                end
                OP_DISCONNECT: begin
                    s = slot_of(it.link_handle);
                    if (s >= 0) begin
                        valid[s] = 0; r.ok = 1; r.result_handle = it.link_handle;
                    end
                end
                OP_FIND_BY_ADDRESS: begin
                    for (int i = 0; i < LINKS; i++)
                        if (valid[i] && ent[i].address == it.peer_address &&
                            (!r.ok || ent[i].handle < r.result_handle)) begin
                            r.ok = 1; r.result_handle = ent[i].handle;
                        end
                end
                OP_QUERY_HANDLE: begin
                    s = slot_of(it.link_handle);
                    if (s >= 0) begin
                        r.ok = 1; r.result_handle = it.link_handle;
                        r.result_address = ent[s].address;
                        r.result_address_type = ent[s].addr_type;
                        r.result_local_type = ent[s].local_type;
                        r.result_encrypted = ent[s].encrypted;
                    end
                end
                OP_ENCRYPT: begin
                    s = slot_of(it.link_handle);
                    if (s >= 0) begin
                        ent[s].encrypted = 1; r.ok = 1; r.result_handle = it.link_handle;
                    end
                end
                OP_DEVICE_CONNECTED: r.ok = present(it.peer_address, it.peer_address_type);
                OP_HAS_PEND_CLASSIC: r.ok = cl_m;
                OP_HAS_PEND_LE: r.ok = le_m;
                default: ;
            endcase
            pending_results.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp_r;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.ok !== exp_r.ok || got.result_handle !== exp_r.result_handle ||
                got.result_address !== exp_r.result_address ||
                got.result_address_type !== exp_r.result_address_type ||
                got.result_local_type !== exp_r.result_local_type ||
                got.result_encrypted !== exp_r.result_encrypted ||
                got.table_full !== exp_r.table_full) begin
                $display("%0t: expected %h actual %h", $time, exp_r, got);
                errors++;
            end
        endfunction
    endclass

    logic      clk = 0;
    logic      rst_n = 0;
    logic      in_valid = 0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 0;
    t_out_item out_item;
    bit        calm = 0;
    int        n_sent = 0;

    link_table_scoreboard sb = new();

    // Small address pool so that pend, complete and find collide often.
    logic [47:0] addr_pool [8];
    logic [7:0]  type_pool [3];

    always #2 clk = ~clk;

    link_connection_table u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_item(out_item)
    );

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_result(out_item);
        if (rst_n) out_ready <= calm || ($urandom_range(99) >= 37);
    end

    // Valid stays high from one transaction to the next unless an idle gap is drawn.
    task automatic send_item(t_in_item it);
        if (!calm && $urandom_range(99) < 37) begin
            in_valid <= 0;
            @(posedge clk);
            while (!calm && $urandom_range(99) < 37) @(posedge clk);
        end
        in_item <= it;
        in_valid <= 1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(it);
        n_sent++;
    endtask

    function automatic t_in_item make_item(t_op op);
        t_in_item it;
        it.operation = op;
        it.peer_address = addr_pool[$urandom_range(7)];
        it.peer_address_type = type_pool[$urandom_range(2)];
        it.local_address_type = 8'($urandom);
        if ($urandom_range(9) < 7 && sb.cursor > 0)
            it.link_handle = 12'($urandom_range(sb.cursor - 1) > 20 ?
                sb.cursor - 1 - $urandom_range(20) : $urandom_range(sb.cursor - 1));
        else
            it.link_handle = 12'($urandom);
        return it;
    endfunction

    task automatic run_sequence();
        t_in_item it;
        int k;
        k = $urandom_range(9);
        if (k < 4) begin
            it = make_item(OP_PEND_CLASSIC);
            send_item(it);
            if ($urandom_range(3) == 0) begin
                it.operation = OP_HAS_PEND_CLASSIC;
                send_item(it);
            end
            it.operation = ($urandom_range(4) == 0) ? OP_CANCEL_CLASSIC : OP_COMPLETE_CLASSIC;
            send_item(it);
        end else if (k < 8) begin
            it = make_item(OP_PEND_LE);
            send_item(it);
            if ($urandom_range(3) == 0) begin
                it.operation = OP_HAS_PEND_LE;
                send_item(it);
            end
            it.operation = ($urandom_range(4) == 0) ? OP_CANCEL_LE : OP_COMPLETE_LE;
            it.local_address_type = 8'($urandom);
            send_item(it);
        end else begin
            it = make_item(t_op'($urandom_range(15)));
            if ($urandom_range(9) == 0)
                it = t_in_item'(80'({$urandom, $urandom, $urandom}));
            send_item(it);
        end
        if ($urandom_range(3) == 0) begin
            it = make_item(t_op'($urandom_range(OP_DISCONNECT, OP_HAS_PEND_LE)));
            send_item(it);
        end
    endtask

    initial begin
        t_in_item it;
        foreach (addr_pool[i]) addr_pool[i] = 48'({$urandom, $urandom});
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        type_pool = '{8'h00, 8'hFF, LCT_LE_TYPE_IDLE};
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // Directed part: queries on an empty table, extremes, a full table.
        it = '0;
        it.operation = OP_HAS_PEND_LE;
        it.peer_address = '0;
        it.peer_address_type = LCT_LE_TYPE_IDLE;
        send_item(it);
        it.link_handle = '1; it.operation = OP_QUERY_HANDLE; send_item(it);
        it.operation = t_op'(4'd13); send_item(it);
        it = '1; it.operation = t_op'(4'd15); send_item(it);
        it.operation = OP_PEND_LE; send_item(it);
        it.operation = OP_PEND_LE; send_item(it);
        it.operation = OP_DEVICE_CONNECTED; send_item(it);
        it.operation = OP_COMPLETE_LE; send_item(it);
        it.operation = OP_PEND_LE; send_item(it);
        it.operation = OP_DEVICE_CONNECTED; send_item(it);
        it.operation = OP_ENCRYPT; it.link_handle = 12'd0; send_item(it);
        it.operation = OP_QUERY_HANDLE; send_item(it);
        it.operation = OP_CANCEL_CLASSIC; send_item(it);
        it.operation = OP_CANCEL_LE; send_item(it);
        for (int i = 0; i < 17; i++) begin
            it.operation = OP_PEND_CLASSIC; it.peer_address = 48'(i); send_item(it);
            it.operation = OP_COMPLETE_CLASSIC; send_item(it);
        end
        it.operation = OP_FIND_BY_ADDRESS; it.peer_address = 48'd3; send_item(it);
        it.operation = OP_CANCEL_CLASSIC; it.peer_address = 48'd16; send_item(it);
        for (int h = 0; h < 16; h++) begin
            it.operation = OP_DISCONNECT; it.link_handle = 12'(h); send_item(it);
        end
        // Random part; the middle stretch runs with no idling at all.
        while (n_sent < 550) begin
            calm = (n_sent > 250 && n_sent < 330);
            run_sequence();
        end
        calm = 0;
        in_valid <= 0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("link_connection_table: match");
        else
            $display("link_connection_table: mismatch");
        $finish;
    end

    initial begin
        #4000000;
        $display("link_connection_table: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/lct_pkg.sv
rtl/lct_store.sv
rtl/link_connection_table.sv
sim/testbench.sv
